// ===== hdl/lnf_pkg.sv =====
// shared types and constants of the lcd number formatter
`default_nettype none

package lnf_pkg;

  // defaults of the top-level parameters
  localparam int MAX_DIGITS_DEF   = 16;
  localparam int NUMBER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // widest values that the parameter ranges allow inside a queued item
  localparam int VAL_W_MAX = 32;
  localparam int CNT_W_MAX = 6;

  // lcd command and character codes
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LINE2_OFFSET  = 8'h40;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;

  // display lines that get a cursor command
  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  typedef enum logic [1:0] {
    MODE_UDEC = 2'd0,
    MODE_SDEC = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_BIN  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2
  } base_e;

  // one display request
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  line;
    logic [4:0]  column;
    logic [15:0] number;
    logic [4:0]  digit_count;
  } req_t;

  // one lcd bus write
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } res_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic                 has_cmd;
    logic [7:0]           cmd_byte;
    logic                 has_sign;
    logic                 negative;
    base_e                base;
    logic [CNT_W_MAX-1:0] count;
    logic [VAL_W_MAX-1:0] magnitude;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/lcd_number_formatter.sv =====
// lcd number formatter: number display request to a run of lcd bus writes
// the request passes the front-end item register and the queue; the back end then
// converts its digits, one digit per cycle, and sends one write per cycle; it pops
// a new item only after the last write of the one before; the queue holds the rest
// writes come out one per cycle for one cycle each; the receiver cannot stall
// reset: asynchronous, clears the queue and sequencer, no clearing pass needed
`default_nettype none

module lcd_number_formatter #(
  parameter int MAX_DIGITS   = lnf_pkg::MAX_DIGITS_DEF,
  parameter int NUMBER_WIDTH = lnf_pkg::NUMBER_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = lnf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire lnf_pkg::req_t req_i,
  output logic               busy,
  output logic               res_valid_o,
  output lnf_pkg::res_t      res_o
);

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  lnf_pkg::job_t q_wdata;
  lnf_pkg::job_t q_rdata;

  // request intake and classification
  lnf_front #(
    .MAX_DIGITS  (MAX_DIGITS),
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .req_i   (req_i),
    .busy    (busy),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  // item queue
  lnf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  // conversion and write sequencing
  lnf_back #(
    .MAX_DIGITS  (MAX_DIGITS),
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lnf_front.sv =====
// front end: takes requests and classifies them into queue items
`default_nettype none

module lnf_front #(
  parameter int MAX_DIGITS   = lnf_pkg::MAX_DIGITS_DEF,
  parameter int NUMBER_WIDTH = lnf_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire lnf_pkg::req_t req_i,
  output logic               busy,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output lnf_pkg::job_t      q_data_o
);

  localparam int VW = lnf_pkg::VAL_W_MAX;
  localparam int CN = lnf_pkg::CNT_W_MAX;

  logic          valid_q, valid_d;
  lnf_pkg::job_t job_q, job_d;
  logic          accept;

  logic [31:0]             num_ext;
  logic [NUMBER_WIDTH-1:0] val;
  logic [NUMBER_WIDTH-1:0] mag;
  logic                    neg;
  logic [7:0]              addr;
  logic [CN-1:0]           cnt_raw;

  // stage is held while the queue is full
  assign busy     = valid_q & q_full_i;
  assign accept   = start & ~busy;
  assign q_push_o = valid_q & ~q_full_i;
  assign q_data_o = job_q;

  // classification of the incoming request
  always_comb begin
    num_ext = {16'b0, req_i.number};
    val     = num_ext[NUMBER_WIDTH-1:0];
    neg     = (lnf_pkg::mode_e'(req_i.mode) == lnf_pkg::MODE_SDEC) & val[NUMBER_WIDTH-1];
    mag     = neg ? NUMBER_WIDTH'(~val + 1'b1) : val;
    addr    = {3'b0, req_i.column} - 8'd1
            + ((req_i.line == lnf_pkg::LINE_TWO) ? lnf_pkg::LINE2_OFFSET : 8'd0);
    cnt_raw = {1'b0, req_i.digit_count};

    job_d.has_cmd   = (req_i.line == lnf_pkg::LINE_ONE) | (req_i.line == lnf_pkg::LINE_TWO);
    job_d.cmd_byte  = lnf_pkg::CMD_SET_DDRAM | addr;
    job_d.negative  = neg;
    job_d.magnitude = VW'(mag);
    job_d.count     = (cnt_raw > CN'(MAX_DIGITS)) ? CN'(MAX_DIGITS) : cnt_raw;

    unique case (lnf_pkg::mode_e'(req_i.mode))
      lnf_pkg::MODE_SDEC: begin
        job_d.has_sign = 1'b1;
        job_d.base     = lnf_pkg::BASE_DEC;
      end
      lnf_pkg::MODE_HEX: begin
        job_d.has_sign = 1'b0;
        job_d.base     = lnf_pkg::BASE_HEX;
      end
      lnf_pkg::MODE_BIN: begin
        job_d.has_sign = 1'b0;
        job_d.base     = lnf_pkg::BASE_BIN;
      end
      default: begin
        job_d.has_sign = 1'b0;
        job_d.base     = lnf_pkg::BASE_DEC;
      end
    endcase
  end

  // stage occupancy
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // item register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lnf_fifo.sv =====
// short queue of classified items between front end and back end
`default_nettype none

module lnf_fifo #(
  parameter int DEPTH = lnf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lnf_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output lnf_pkg::job_t      data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lnf_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          do_push, do_pop;

  assign full_o  = (fill_q == CW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lnf_back.sv =====
// back end: digit conversion and sequencing of lcd bus writes
`default_nettype none

module lnf_back #(
  parameter int MAX_DIGITS   = lnf_pkg::MAX_DIGITS_DEF,
  parameter int NUMBER_WIDTH = lnf_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire lnf_pkg::job_t q_data_i,
  output logic               q_pop_o,
  output logic               res_valid_o,
  output lnf_pkg::res_t      res_o
);

  localparam int NW = NUMBER_WIDTH;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CMD,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e          state_q, state_d;
  logic [NW-1:0]   val_q, val_d;
  lnf_pkg::base_e  base_q, base_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            has_cmd_q, has_cmd_d;
  logic [7:0]      cmd_q, cmd_d;
  logic            has_sign_q, has_sign_d;
  logic            neg_q, neg_d;
  logic            res_valid_q, res_valid_d;
  lnf_pkg::res_t   res_q, res_d;
  logic [3:0]      digits_q [MAX_DIGITS];

  logic [31:0]     v_ext;
  logic [63:0]     prod;
  logic [31:0]     quo;
  logic [31:0]     rem;
  logic [3:0]      dig;
  logic [NW-1:0]   val_next;
  logic            dig_we;
  logic [IW-1:0]   wr_idx;
  logic [IW-1:0]   rd_idx;
  logic [CW-1:0]   cnt_inc;
  logic [CW-1:0]   cnt_dec;
  logic [3:0]      rd_dig;
  logic [7:0]      rd_char;
  logic [CW-1:0]   ld_count;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // divide by ten through reciprocal multiply, exact for 32-bit values
  always_comb begin
    v_ext = 32'(val_q);
    prod  = {32'b0, v_ext} * 64'h0000_0000_CCCC_CCCD;
    quo   = {3'b0, prod[63:35]};
    rem   = v_ext - ((quo << 3) + (quo << 1));
  end

  // digit extraction per base
  always_comb begin
    unique case (base_q)
      lnf_pkg::BASE_HEX: begin
        dig      = val_q[3:0];
        val_next = val_q >> 4;
      end
      lnf_pkg::BASE_BIN: begin
        dig      = {3'b0, val_q[0]};
        val_next = val_q >> 1;
      end
      default: begin
        dig      = rem[3:0];
        val_next = quo[NW-1:0];
      end
    endcase
  end

  // digit indexes and character of the digit being sent
  always_comb begin
    cnt_inc = cnt_q + 1'b1;
    cnt_dec = cnt_q - 1'b1;
    wr_idx  = cnt_q[IW-1:0];
    rd_idx  = cnt_dec[IW-1:0];
    rd_dig  = digits_q[rd_idx];
    if (rd_dig < 4'd10) begin
      rd_char = lnf_pkg::CHAR_ZERO + {4'b0, rd_dig};
    end else begin
      rd_char = lnf_pkg::CHAR_UPPER_A + {4'b0, rd_dig} - 8'd10;
    end
    ld_count = q_data_i.count[CW-1:0];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    base_d      = base_q;
    count_d     = count_q;
    cnt_d       = cnt_q;
    has_cmd_d   = has_cmd_q;
    cmd_d       = cmd_q;
    has_sign_d  = has_sign_q;
    neg_d       = neg_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    dig_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o    = 1'b1;
          val_d      = q_data_i.magnitude[NW-1:0];
          base_d     = q_data_i.base;
          count_d    = ld_count;
          cnt_d      = '0;
          has_cmd_d  = q_data_i.has_cmd;
          cmd_d      = q_data_i.cmd_byte;
          has_sign_d = q_data_i.has_sign;
          neg_d      = q_data_i.negative;
          if (ld_count != '0) begin
            state_d = ST_CONV;
          end else if (q_data_i.has_cmd) begin
            state_d = ST_CMD;
          end else if (q_data_i.has_sign) begin
            state_d = ST_SIGN;
          end
        end
      end
      ST_CONV: begin
        dig_we = 1'b1;
        val_d  = val_next;
        cnt_d  = cnt_inc;
        if (cnt_inc == count_q) begin
          if (has_cmd_q) begin
            state_d = ST_CMD;
          end else if (has_sign_q) begin
            state_d = ST_SIGN;
          end else begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_CMD: begin
        res_valid_d    = 1'b1;
        res_d.is_data  = 1'b0;
        res_d.bus_byte = cmd_q;
        res_d.last     = ~has_sign_q & (count_q == '0);
        if (has_sign_q) begin
          state_d = ST_SIGN;
        end else if (count_q != '0) begin
          state_d = ST_DIGIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SIGN: begin
        res_valid_d    = 1'b1;
        res_d.is_data  = 1'b1;
        res_d.bus_byte = neg_q ? lnf_pkg::CHAR_MINUS : lnf_pkg::CHAR_PLUS;
        res_d.last     = (count_q == '0);
        state_d        = (count_q != '0) ? ST_DIGIT : ST_IDLE;
      end
      ST_DIGIT: begin
        res_valid_d    = 1'b1;
        res_d.is_data  = 1'b1;
        res_d.bus_byte = rd_char;
        res_d.last     = (cnt_q == CW'(1));
        cnt_d          = cnt_dec;
        if (cnt_q == CW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      val_q       <= '0;
      base_q      <= lnf_pkg::BASE_DEC;
      count_q     <= '0;
      cnt_q       <= '0;
      has_cmd_q   <= 1'b0;
      cmd_q       <= '0;
      has_sign_q  <= 1'b0;
      neg_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      val_q       <= val_d;
      base_q      <= base_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      has_cmd_q   <= has_cmd_d;
      cmd_q       <= cmd_d;
      has_sign_q  <= has_sign_d;
      neg_q       <= neg_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  // digit store, least significant digit at index zero
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[wr_idx] <= dig;
    end
  end

endmodule

`default_nettype wire

// ===== bench/lcd_number_formatter_tb.sv =====
// testbench of the lcd number formatter: directed and random requests checked write by write
`timescale 1ns / 100ps

module lcd_number_formatter_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int MAX_SHOWN      = 16;
  localparam int GAP_PERCENT    = 28;

  // line values that get no cursor command
  localparam logic [1:0] LINE_OFF_LOW  = 2'd0;
  localparam logic [1:0] LINE_OFF_HIGH = 2'd3;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  lnf_pkg::req_t req_i;
  logic          busy;
  logic          res_valid_o;
  lnf_pkg::res_t res_o;

  // bus writes still owed by the block, oldest first
  lnf_pkg::res_t bus_writes_due[$];
  int            fault_count;
  int            stall_cycles;
  bit            gaps_allowed;

  lcd_number_formatter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // queue one expected write
  function automatic void push_bus_write(input logic is_data, input logic [7:0] bus_byte,
                                         input logic last);
    lnf_pkg::res_t wr;
    wr.is_data  = is_data;
    wr.bus_byte = bus_byte;
    wr.last     = last;
    bus_writes_due.push_back(wr);
  endfunction

  // work out the writes that one request causes
  function automatic void predict_bus_writes(input lnf_pkg::req_t rq);
    logic [7:0]  addr;
    logic [7:0]  ch;
    logic [3:0]  digs [MAX_SHOWN];
    int unsigned mag;
    int unsigned base;
    int          ndig;
    int          total;
    int          k;
    bit          has_cmd;
    bit          has_sign;
    addr     = '0;
    ch       = '0;
    k        = 0;
    ndig     = (rq.digit_count > MAX_SHOWN) ? MAX_SHOWN : int'(rq.digit_count);
    has_cmd  = (rq.line == lnf_pkg::LINE_ONE) || (rq.line == lnf_pkg::LINE_TWO);
    has_sign = (rq.mode == lnf_pkg::MODE_SDEC);
    total    = int'(has_cmd) + int'(has_sign) + ndig;
    mag      = 32'(rq.number);
    // cursor address wraps at eight bits
    if (has_cmd) begin
      addr = {3'b000, rq.column} - 8'd1
           + ((rq.line == lnf_pkg::LINE_TWO) ? lnf_pkg::LINE2_OFFSET : 8'h00);
      push_bus_write(1'b0, lnf_pkg::CMD_SET_DDRAM | addr, k == total - 1);
      k++;
    end
    // sign character, digits then come from the magnitude
    if (has_sign) begin
      if (rq.number[15]) begin
        push_bus_write(1'b1, lnf_pkg::CHAR_MINUS, k == total - 1);
        mag = 32'h1_0000 - 32'(rq.number);
      end else begin
        push_bus_write(1'b1, lnf_pkg::CHAR_PLUS, k == total - 1);
      end
      k++;
    end
    case (rq.mode)
      lnf_pkg::MODE_HEX: base = 16;
      lnf_pkg::MODE_BIN: base = 2;
      default:           base = 10;
    endcase
    for (int p = 0; p < ndig; p++) begin
      digs[p] = 4'(mag % base);
      mag     = mag / base;
    end
    // most significant digit first
    for (int p = ndig - 1; p >= 0; p--) begin
      ch = (digs[p] < 4'd10) ? lnf_pkg::CHAR_ZERO + {4'b0, digs[p]}
                             : lnf_pkg::CHAR_UPPER_A + {4'b0, digs[p]} - 8'd10;
      push_bus_write(1'b1, ch, k == total - 1);
      k++;
    end
  endfunction

  // result checking, prediction on acceptance, and the watchdog
  always @(posedge clk_i) begin : bus_monitor
    lnf_pkg::res_t due;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (bus_writes_due.size() == 0) begin
          $error("unexpected bus write: is_data %0b bus_byte %h last %0b",
                 res_o.is_data, res_o.bus_byte, res_o.last);
          fault_count++;
        end else begin
          due = bus_writes_due.pop_front();
          if (res_o.is_data !== due.is_data) begin
            $error("is_data: expected %0b, got %0b", due.is_data, res_o.is_data);
            fault_count++;
          end
          if (res_o.bus_byte !== due.bus_byte) begin
            $error("bus_byte: expected %h, got %h", due.bus_byte, res_o.bus_byte);
            fault_count++;
          end
          if (res_o.last !== due.last) begin
            $error("last: expected %0b, got %0b", due.last, res_o.last);
            fault_count++;
          end
        end
      end
      if (start && !busy) predict_bus_writes(req_i);
      if (res_valid_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("lcd_number_formatter_tb failed");
        $finish;
      end
    end
  end

  // hand one request over, idling now and then before it while gaps are allowed
  task automatic send_req(input logic [1:0] md, input logic [1:0] ln, input logic [4:0] col,
                          input logic [15:0] num, input logic [4:0] cnt);
    lnf_pkg::req_t rq;
    rq.mode        = md;
    rq.line        = ln;
    rq.column      = col;
    rq.number      = num;
    rq.digit_count = cnt;
    while (gaps_allowed && ($urandom_range(99) < GAP_PERCENT)) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  // random request, within the documented ranges in the given percentage of calls
  task automatic send_random_req(input int well_formed_percent);
    logic [1:0]  md;
    logic [1:0]  ln;
    logic [4:0]  col;
    logic [15:0] num;
    logic [4:0]  cnt;
    md = 2'($urandom_range(3));
    if ($urandom_range(99) < well_formed_percent) begin
      ln  = $urandom_range(1) ? lnf_pkg::LINE_TWO : lnf_pkg::LINE_ONE;
      col = 5'($urandom_range(16, 1));
      cnt = 5'($urandom_range(16, 1));
    end else begin
      ln  = 2'($urandom_range(3));
      col = 5'($urandom_range(31));
      cnt = 5'($urandom_range(31));
    end
    case ($urandom_range(3))
      0:       num = 16'($urandom_range(20));
      1:       num = ($urandom_range(1) ? 16'h8000 : 16'h0000) |
                     ($urandom_range(1) ? 16'h7FFF : 16'h0000);
      default: num = 16'($urandom_range(16'hFFFF));
    endcase
    send_req(md, ln, col, num, cnt);
  endtask

  // hold off until every owed write has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (bus_writes_due.size() != 0);
    @(posedge clk_i);
  endtask

  // extremes of every field, each mode and the corner cases
  task automatic test_directed_extremes();
    send_req(lnf_pkg::MODE_UDEC, lnf_pkg::LINE_ONE, 5'd1,  16'h0000, 5'd1);
    send_req(lnf_pkg::MODE_UDEC, lnf_pkg::LINE_TWO, 5'd16, 16'hFFFF, 5'd5);
    // count saturates, upper places read as zero
    send_req(lnf_pkg::MODE_UDEC, lnf_pkg::LINE_ONE, 5'd31, 16'hFFFF, 5'd31);
    // signed zero on column zero
    send_req(lnf_pkg::MODE_SDEC, lnf_pkg::LINE_ONE, 5'd0,  16'h0000, 5'd3);
    // most negative value
    send_req(lnf_pkg::MODE_SDEC, lnf_pkg::LINE_TWO, 5'd0,  16'h8000, 5'd5);
    send_req(lnf_pkg::MODE_SDEC, LINE_OFF_HIGH,     5'd5,  16'hFFFF, 5'd16);
    // sign alone, no cursor
    send_req(lnf_pkg::MODE_SDEC, LINE_OFF_LOW,      5'd2,  16'h7FFF, 5'd0);
    send_req(lnf_pkg::MODE_HEX,  lnf_pkg::LINE_ONE, 5'd8,  16'hABCD, 5'd4);
    send_req(lnf_pkg::MODE_HEX,  lnf_pkg::LINE_TWO, 5'd3,  16'hFFFF, 5'd16);
    // request with no writes at all
    send_req(lnf_pkg::MODE_HEX,  LINE_OFF_LOW,      5'd0,  16'h0000, 5'd0);
    send_req(lnf_pkg::MODE_BIN,  lnf_pkg::LINE_ONE, 5'd1,  16'hAAAA, 5'd16);
    send_req(lnf_pkg::MODE_BIN,  lnf_pkg::LINE_TWO, 5'd16, 16'h5555, 5'd31);
    send_req(lnf_pkg::MODE_BIN,  LINE_OFF_HIGH,     5'd31, 16'hFFFF, 5'd1);
    send_req(lnf_pkg::MODE_UDEC, LINE_OFF_HIGH,     5'd7,  16'h1234, 5'd0);
    send_req(lnf_pkg::MODE_HEX,  lnf_pkg::LINE_TWO, 5'd31, 16'h00F0, 5'd2);
    wait_drained();
  endtask

  // random requests with gaps on the sending side
  task automatic test_random_with_gaps();
    repeat (120) send_random_req(85);
    wait_drained();
  endtask

  // a long run of requests offered every cycle
  task automatic test_back_to_back();
    gaps_allowed = 1'b0;
    repeat (60) send_random_req(85);
    gaps_allowed = 1'b1;
  endtask

  // out-of-range lines, columns and counts mixed in
  task automatic test_random_noise();
    repeat (65) send_random_req(40);
  endtask

  // stimulus and final verdict
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    fault_count  = 0;
    stall_cycles = 0;
    gaps_allowed = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_random_with_gaps();
    test_back_to_back();
    test_random_noise();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && bus_writes_due.size() == 0) begin
      $display("lcd_number_formatter_tb passed");
    end else begin
      if (bus_writes_due.size() != 0)
        $error("%0d bus writes never came out", bus_writes_due.size());
      $display("lcd_number_formatter_tb failed");
    end
    $finish;
  end

endmodule
